@@ rtl/core/ogru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid package
// Shared types and constants for the ray update block.
// ----------------------------------------------------------------------------
package ogru_pkg;

    // Status codes of a result beat.
    localparam logic [2:0] ST_RAY_OK    = 3'd0;
    localparam logic [2:0] ST_END_OUT   = 3'd1;
    localparam logic [2:0] ST_START_OUT = 3'd2;
    localparam logic [2:0] ST_READ_OK   = 3'd3;
    localparam logic [2:0] ST_READ_OUT  = 3'd4;

    // Operation codes of an input beat.
    localparam logic OP_RAY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COUNT_MODE = 3'd0;
    localparam logic [2:0] CFG_MAP_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_MAP_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_FREE_DELTA = 3'd3;
    localparam logic [2:0] CFG_OCC_DELTA  = 3'd4;
    localparam logic [2:0] CFG_FLOOR      = 3'd5;
    localparam logic [2:0] CFG_CEILING    = 3'd6;

    localparam logic [6:0] SCORE_UNKNOWN = 7'd50;
    localparam logic signed [7:0] PUB_OCC     = 8'sd100;
    localparam logic signed [7:0] PUB_FREE    = 8'sd0;
    localparam logic signed [7:0] PUB_UNKNOWN = -8'sd1;
    localparam logic [9:0] TOUCH_MAX = 10'd1023;

    // Classified job handed from the front part to the back part.
    typedef struct packed {
        logic        is_read;
        logic        skip;
        logic [2:0]  status;
        logic        steep;
        logic signed [12:0] ax;
        logic signed [12:0] ay;
        logic signed [12:0] bx;
        logic signed [12:0] span;
        logic signed [12:0] rise;
        logic        step_neg;
        logic signed [11:0] tx;
        logic signed [11:0] ty;
    } t_job;

endpackage

@@ rtl/core/occupancy_grid_ray_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid ray update
// Bresenham ray marking into a score or hit/miss map, plus cell reads.
// ----------------------------------------------------------------------------
// After reset the block clears its map with full high. A ray whose Bresenham
// line holds L cells (at most MAP_SIDE) passes the address, read and write
// states on each updated cell, one memory read-modify-write through the single
// map port, and steps over the end cell in the address state before that cell
// is updated as hit. A read passes the address, read and write states once;
// a skipped ray goes straight to the result state.
// The front holds one classified job while the back walks, and the back may
// start that job while the previous result still waits in the one-beat output
// register; it then stalls only when its own result is ready.
module occupancy_grid_ray_update #(
    parameter int MAP_SIDE   = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_op,
    input  logic signed [11:0] i_start_x,
    input  logic signed [11:0] i_start_y,
    input  logic signed [11:0] i_target_x,
    input  logic signed [11:0] i_target_y,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_status,
    output logic signed [7:0]  o_cell_value,
    output logic [9:0]         o_cells_touched,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data
);
    import ogru_pkg::*;

    logic              r_count_mode;
    logic [8:0]        r_width, r_height;
    logic signed [7:0] r_free_delta, r_occ_delta;
    logic [6:0]        r_floor, r_ceiling;
    logic [9:0]        eff_w, eff_h;
    logic              f_ready, j_valid, j_ready, clearing, res_valid;
    t_job              job;

    // Map size is limited to the built side.
    assign eff_w = (int'(r_width)  > MAP_SIDE) ? 10'(MAP_SIDE) : {1'b0, r_width};
    assign eff_h = (int'(r_height) > MAP_SIDE) ? 10'(MAP_SIDE) : {1'b0, r_height};

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_mode <= 1'b0;
            r_width      <= 9'd256;
            r_height     <= 9'd256;
            r_free_delta <= -8'sd1;
            r_occ_delta  <= 8'sd2;
            r_floor      <= 7'd0;
            r_ceiling    <= 7'd100;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COUNT_MODE: r_count_mode <= i_cfg_data[0];
                CFG_MAP_WIDTH:  r_width      <= i_cfg_data;
                CFG_MAP_HEIGHT: r_height     <= i_cfg_data;
                CFG_FREE_DELTA: r_free_delta <= i_cfg_data[7:0];
                CFG_OCC_DELTA:  r_occ_delta  <= i_cfg_data[7:0];
                CFG_FLOOR:      r_floor      <= i_cfg_data[6:0];
                CFG_CEILING:    r_ceiling    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign full = !f_ready || clearing;

    ogru_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(push && !clearing), .o_ready(f_ready),
        .i_op, .i_start_x, .i_start_y, .i_target_x, .i_target_y,
        .i_eff_w(eff_w), .i_eff_h(eff_h),
        .o_valid(j_valid), .i_ready(j_ready), .o_job(job)
    );

    ogru_back #(.MAP_SIDE(MAP_SIDE), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(j_valid), .o_ready(j_ready), .i_job(job),
        .i_count_mode(r_count_mode), .i_eff_w(eff_w),
        .i_free_delta(r_free_delta), .i_occ_delta(r_occ_delta),
        .i_floor(r_floor), .i_ceiling(r_ceiling),
        .o_clearing(clearing),
        .o_res_valid(res_valid), .i_res_ready(pop),
        .o_status, .o_cell_value, .o_cells_touched
    );

    assign empty = !res_valid;

    // A result that is not popped stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_status))
        else $error("result changed while waiting");
    // Skipped or read beats report no touched cells.
    a_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status != ST_RAY_OK |-> o_cells_touched == 10'd0)
        else $error("touched count on non-ray result");
    // No input is taken while the map is cleared.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> full)
        else $error("input accepted during clear");
endmodule

@@ rtl/core/ogru_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid front end
// Checks bounds and orders a ray into a Bresenham job; registered output.
// ----------------------------------------------------------------------------
module ogru_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic signed [11:0] i_start_x,
    input  logic signed [11:0] i_start_y,
    input  logic signed [11:0] i_target_x,
    input  logic signed [11:0] i_target_y,
    input  logic [9:0]         i_eff_w,
    input  logic [9:0]         i_eff_h,
    output logic               o_valid,
    input  logic               i_ready,
    output ogru_pkg::t_job     o_job
);
    import ogru_pkg::*;

    logic   r_valid;
    t_job   r_job;
    t_job   n_job;

    logic t_in, s_in, steep;
    logic signed [12:0] ax, ay, bx, by, dx, dy, adx, ady, ux, uy, vx, vy;

    function automatic logic inside_map(input logic signed [11:0] x,
                                        input logic signed [11:0] y,
                                        input logic [9:0] w, input logic [9:0] h);
        return !x[11] && !y[11] && ({1'b0, x[10:0]} < {2'b0, w})
            && ({1'b0, y[10:0]} < {2'b0, h});
    endfunction

    // Classification and Bresenham setup.
    always_comb begin
        t_in  = inside_map(i_target_x, i_target_y, i_eff_w, i_eff_h);
        s_in  = inside_map(i_start_x, i_start_y, i_eff_w, i_eff_h);
        dx    = 13'(i_target_x) - 13'(i_start_x);
        dy    = 13'(i_target_y) - 13'(i_start_y);
        adx   = dx[12] ? -dx : dx;
        ady   = dy[12] ? -dy : dy;
        steep = ady > adx;
        ux = steep ? 13'(i_start_y) : 13'(i_start_x);
        uy = steep ? 13'(i_start_x) : 13'(i_start_y);
        vx = steep ? 13'(i_target_y) : 13'(i_target_x);
        vy = steep ? 13'(i_target_x) : 13'(i_target_y);
        if (ux > vx) begin
            ax = vx; ay = vy; bx = ux; by = uy;
        end else begin
            ax = ux; ay = uy; bx = vx; by = vy;
        end
        n_job          = '0;
        n_job.is_read  = (i_op == OP_READ);
        n_job.steep    = steep;
        n_job.ax       = ax;
        n_job.ay       = ay;
        n_job.bx       = bx;
        n_job.span     = bx - ax;
        n_job.rise     = (by < ay) ? (ay - by) : (by - ay);
        n_job.step_neg = !(ay < by);
        n_job.tx       = i_target_x;
        n_job.ty       = i_target_y;
        if (i_op == OP_READ) begin
            n_job.skip   = !t_in;
            n_job.status = t_in ? ST_READ_OK : ST_READ_OUT;
        end else if (!t_in) begin
            n_job.skip = 1'b1; n_job.status = ST_END_OUT;
        end else if (!s_in) begin
            n_job.skip = 1'b1; n_job.status = ST_START_OUT;
        end else begin
            n_job.status = ST_RAY_OK;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    // One-entry job register between the two halves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule

@@ rtl/core/ogru_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid back end
// Walks the ray one cell per read-modify-write pass over the map memories.
// ----------------------------------------------------------------------------
module ogru_back #(
    parameter int MAP_SIDE   = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ogru_pkg::t_job      i_job,
    input  logic                i_count_mode,
    input  logic [9:0]          i_eff_w,
    input  logic signed [7:0]   i_free_delta,
    input  logic signed [7:0]   i_occ_delta,
    input  logic [6:0]          i_floor,
    input  logic [6:0]          i_ceiling,
    output logic                o_clearing,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [2:0]          o_status,
    output logic signed [7:0]   o_cell_value,
    output logic [9:0]          o_cells_touched
);
    import ogru_pkg::*;

    localparam int CELLS = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADDR, S_READ, S_WRITE, S_RESULT
    } t_state;

    logic [6:0]            r_score [CELLS];
    logic [COUNT_BITS-1:0] r_hits  [CELLS];
    logic [COUNT_BITS-1:0] r_miss  [CELLS];

    t_state r_state;
    t_job   r_job;
    logic [AW:0] r_clr;
    logic signed [12:0] r_x, r_y, r_err;
    logic [9:0] r_touched;
    logic       r_hit_phase;
    logic [AW-1:0] r_addr;
    logic [6:0]    r_sc_q;
    logic [COUNT_BITS-1:0] r_h_q, r_m_q;
    logic       r_res_valid;
    logic [2:0] r_status;
    logic signed [7:0] r_value;
    logic [9:0] r_cells;

    logic signed [12:0] px, py, cx, cy, n_err, n_y;
    logic [AW-1:0] idx;
    logic is_target, last;
    logic signed [9:0] sum_free, sum_hit;
    logic [6:0] new_free, new_hit;
    logic [COUNT_BITS+2:0] h5, tot2;
    logic signed [7:0] pub;
    logic [9:0] touch_inc;

    // Current walk cell and Bresenham step.
    always_comb begin
        px = r_job.steep ? r_y : r_x;
        py = r_job.steep ? r_x : r_y;
        cx = r_hit_phase ? 13'(r_job.tx) : px;
        cy = r_hit_phase ? 13'(r_job.ty) : py;
        idx = AW'(cy) + AW'(32'(cx) * 32'(i_eff_w));
        n_err = r_err + r_job.rise;
        n_y   = r_y;
        if ((n_err <<< 1) >= r_job.span) begin
            n_y   = r_job.step_neg ? r_y - 13'sd1 : r_y + 13'sd1;
            n_err = n_err - r_job.span;
        end
        is_target = (px == 13'(r_job.tx)) && (py == 13'(r_job.ty));
        last      = (r_x == r_job.bx);
        touch_inc = (r_touched == TOUCH_MAX) ? r_touched : r_touched + 10'd1;
    end

    // Score update arithmetic and publication.
    always_comb begin
        sum_free = 10'(signed'({1'b0, r_sc_q})) + 10'(i_free_delta);
        if (sum_free < 10'(signed'({1'b0, i_floor}))) sum_free = 10'(i_floor);
        new_free = sum_free[9] ? 7'd0 : ((sum_free > 10'sd127) ? 7'd127 : sum_free[6:0]);
        sum_hit = 10'(signed'({1'b0, r_sc_q})) + 10'(i_occ_delta);
        if (sum_hit > 10'(signed'({1'b0, i_ceiling}))) sum_hit = 10'(i_ceiling);
        new_hit = sum_hit[9] ? 7'd0 : ((sum_hit > 10'sd127) ? 7'd127 : sum_hit[6:0]);
        h5   = ({3'b0, r_h_q} << 2) + {3'b0, r_h_q};
        tot2 = ({3'b0, r_h_q} + {3'b0, r_m_q}) << 1;
        if (i_count_mode) begin
            if (r_h_q == '0 && r_m_q == '0) pub = PUB_UNKNOWN;
            else pub = (h5 > tot2) ? PUB_OCC : PUB_FREE;
        end else begin
            pub = (r_sc_q == SCORE_UNKNOWN) ? PUB_UNKNOWN : signed'({1'b0, r_sc_q});
        end
    end

    // Map memories: registered read, single write port each.
    always_ff @(posedge i_clk) begin
        r_sc_q <= r_score[r_addr];
        r_h_q  <= r_hits[r_addr];
        r_m_q  <= r_miss[r_addr];
        if (r_state == S_CLEAR) begin
            r_score[r_clr[AW-1:0]] <= SCORE_UNKNOWN;
            r_hits[r_clr[AW-1:0]]  <= '0;
            r_miss[r_clr[AW-1:0]]  <= '0;
        end else if (r_state == S_WRITE && !r_job.is_read) begin
            if (!i_count_mode) begin
                r_score[r_addr] <= r_hit_phase ? new_hit : new_free;
            end else if (r_hit_phase) begin
                if (r_h_q != CMAX) r_hits[r_addr] <= r_h_q + 1'b1;
            end else begin
                if (r_m_q != CMAX) r_miss[r_addr] <= r_m_q + 1'b1;
            end
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_clearing = (r_state == S_CLEAR);

    // Walk sequencer with result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) r_res_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(CELLS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_job       <= i_job;
                        r_x         <= i_job.ax;
                        r_y         <= i_job.ay;
                        r_err       <= '0;
                        r_touched   <= '0;
                        r_hit_phase <= i_job.is_read;
                        r_state     <= i_job.skip ? S_RESULT : S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_addr <= idx;
                    if (!r_hit_phase && is_target) begin
                        r_x <= r_x + 13'sd1; r_y <= n_y; r_err <= n_err;
                        if (last) r_hit_phase <= 1'b1;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_WRITE;
                S_WRITE: begin
                    if (r_job.is_read) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_touched <= touch_inc;
                        if (r_hit_phase) begin
                            r_state <= S_RESULT;
                        end else begin
                            r_x <= r_x + 13'sd1; r_y <= n_y; r_err <= n_err;
                            if (last) r_hit_phase <= 1'b1;
                            r_state <= S_ADDR;
                        end
                    end
                end
                S_RESULT: begin
                    if (!r_res_valid) begin
                        r_res_valid <= 1'b1;
                        r_status    <= r_job.status;
                        r_value     <= (r_job.is_read && !r_job.skip) ? pub : 8'sd0;
                        r_cells     <= r_job.skip ? 10'd0 : r_touched;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_status        = r_status;
    assign o_cell_value    = r_value;
    assign o_cells_touched = r_cells;
endmodule
